@@ design/rsa_pkg.sv @@
// shared types and constants for the reference-counted slot allocator
// no dependencies; used by refcounted_slot_allocator_core
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int DEFAULT_SLOT_COUNT = 8;

	localparam int OP_W    = 2;
	localparam int LEN_W   = 24;
	localparam int ID_W    = 4;
	localparam int ADDR_W  = 32;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_INC   = 2'd1,
		OP_DEC   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_POOL_BASE   = 1'b0,
		REG_POOL_LENGTH = 1'b1
	} cfg_reg_t;

	// one entry of the slot memory
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [CNT_W-1:0]  cnt;
	} slot_entry_t;

endpackage

@@ design/refcounted_slot_allocator_core.sv @@
// reference-counted fixed-slot pool allocator, top level
// depends on rsa_pkg
`timescale 1ns / 1ps

// channel  dir  handshake          content
// s_*      in   s_tvalid/s_tready  one operation: op, request_length, slot_id
// m_*      out  m_tvalid/m_tready  one result: result_id, ok, slot_address, slot_length
// cfg_*    in   cfg_we             register write: 0 pool_base, 1 pool_length
//
// each operation is split into accept plus slot-memory read, then modify and write
// back; the synchronous read of the slot memory sets this split.
// a pool_length write sets the slot size at the same edge through a constant reciprocal
// multiply, so s_tready never waits on configuration.
// reset clears all in-use flags at once, no clearing pass.
// a held result in the output register does not block the next beat; a second finished
// result waits in the modify stage until the output register frees up.

module refcounted_slot_allocator_core #(
	parameter int SLOT_COUNT = rsa_pkg::DEFAULT_SLOT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] op, [25:2] request_length, [29:26] slot_id, [31:30] zero
	input  logic [rsa_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] result_id, [4] ok, [36:5] slot_address, [60:37] slot_length, [63:61] zero
	output logic [rsa_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int IW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int XW   = IW + rsa_pkg::ID_W + 1;
	localparam int PW   = IW + rsa_pkg::LEN_W;
	localparam int LW   = rsa_pkg::LEN_W;
	// floor(x / SLOT_COUNT) == (x * ceil(2^RK / SLOT_COUNT)) >> RK for every 24-bit x
	localparam int RK   = LW + $clog2(SLOT_COUNT);
	localparam int RW   = RK + 1;
	localparam longint RECIP = ((longint'(1) << RK) + longint'(SLOT_COUNT) - longint'(1))
		/ longint'(SLOT_COUNT);

	// configuration
	logic [rsa_pkg::ADDR_W-1:0] pool_base_q;
	logic [LW-1:0]              slot_size_q;
	logic [LW+RW-1:0]           len_scaled;

	// in-use flags
	logic [SLOT_COUNT-1:0] in_use_q;

	// accept stage
	rsa_pkg::op_t             op_in;
	logic [LW-1:0]            req_in;
	logic [rsa_pkg::ID_W-1:0] id_in;
	logic [XW-1:0]            id_ext;
	logic [IW-1:0]            id_idx;
	logic                     id_in_range;
	logic                     id_ok;
	logic                     free_found;
	logic [IW-1:0]            free_idx;
	logic                     alloc_ok;
	logic                     accept;

	// modify stage
	logic          s1_valid_q;
	rsa_pkg::op_t  op_s1;
	logic [LW-1:0] req_s1;
	logic          hit_s1;
	logic [IW-1:0] idx_s1;
	logic          complete;

	// slot memory
	rsa_pkg::slot_entry_t mem [SLOT_COUNT];
	rsa_pkg::slot_entry_t rd_entry_q;
	logic [IW-1:0]        rd_idx;
	rsa_pkg::slot_entry_t wr_entry;
	logic                 wr_en;

	// result
	logic [PW-1:0]                 offset;
	logic [XW-1:0]                 rid_ext;
	logic [rsa_pkg::CNT_W-1:0]     cnt_inc;
	logic [rsa_pkg::CNT_W-1:0]     cnt_dec;
	logic [rsa_pkg::ID_W-1:0]      res_id;
	logic                          res_ok;
	logic [rsa_pkg::ADDR_W-1:0]    res_addr;
	logic [LW-1:0]                 res_len;
	logic                          set_use;
	logic                          clr_use;
	logic                          m_tvalid_q;
	logic [rsa_pkg::M_DATA_W-1:0]  m_tdata_q;

	// ---------------- configuration ----------------

	assign len_scaled = (LW+RW)'(cfg_wdata[LW-1:0]) * (LW+RW)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			slot_size_q <= '0;
		end else begin
			if (cfg_we && (cfg_index == rsa_pkg::REG_POOL_BASE)) begin
				pool_base_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_index == rsa_pkg::REG_POOL_LENGTH)) begin
				slot_size_q <= len_scaled[RK +: LW];
			end
		end
	end

	// ---------------- accept stage ----------------

	assign op_in  = rsa_pkg::op_t'(s_tdata[1:0]);
	assign req_in = s_tdata[25:2];
	assign id_in  = s_tdata[29:26];

	assign id_ext      = XW'(id_in) - XW'(1);
	assign id_idx      = id_ext[IW-1:0];
	assign id_in_range = (id_in != '0) && (XW'(id_in) <= XW'(SLOT_COUNT));
	assign id_ok       = id_in_range ? in_use_q[id_idx] : 1'b0;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign alloc_ok = (pool_base_q != '0) && (req_in <= slot_size_q) && free_found;

	assign s_tready = !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign rd_idx   = id_ok ? id_idx : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (complete) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_in;
			req_s1 <= req_in;
			if (op_in == rsa_pkg::OP_ALLOC) begin
				hit_s1 <= alloc_ok;
				idx_s1 <= free_idx;
			end else begin
				hit_s1 <= id_ok;
				idx_s1 <= rd_idx;
			end
		end
	end

	// ---------------- slot memory ----------------

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_entry_q <= mem[rd_idx];
		end
		if (wr_en) begin
			mem[idx_s1] <= wr_entry;
		end
	end

	// ---------------- modify stage ----------------

	assign complete = s1_valid_q && (!m_tvalid_q || m_tready);
	assign offset   = PW'(idx_s1) * PW'(slot_size_q);
	assign rid_ext  = XW'(idx_s1) + XW'(1);
	assign cnt_inc  = rd_entry_q.cnt + 1'b1;
	assign cnt_dec  = rd_entry_q.cnt - 1'b1;

	always_comb begin
		wr_en    = 1'b0;
		wr_entry = rd_entry_q;
		set_use  = 1'b0;
		clr_use  = 1'b0;
		res_id   = '0;
		res_ok   = hit_s1;
		res_addr = '0;
		res_len  = '0;
		case (op_s1)
			rsa_pkg::OP_ALLOC: begin
				if (hit_s1) begin
					wr_en         = complete;
					wr_entry.addr = pool_base_q + rsa_pkg::ADDR_W'(offset);
					wr_entry.len  = req_s1;
					wr_entry.cnt  = rsa_pkg::CNT_W'(1);
					set_use       = complete;
					res_id        = rid_ext[rsa_pkg::ID_W-1:0];
				end
			end
			rsa_pkg::OP_INC: begin
				wr_en        = complete && hit_s1;
				wr_entry.cnt = cnt_inc;
			end
			rsa_pkg::OP_DEC: begin
				wr_en        = complete && hit_s1;
				wr_entry.cnt = cnt_dec;
				clr_use      = complete && hit_s1 && (cnt_dec == '0);
			end
			rsa_pkg::OP_QUERY: begin
				if (hit_s1) begin
					res_addr = rd_entry_q.addr;
					res_len  = rd_entry_q.len;
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (set_use) begin
			in_use_q[idx_s1] <= 1'b1;
		end else if (clr_use) begin
			in_use_q[idx_s1] <= 1'b0;
		end
	end

	// ---------------- output register ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (complete) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			m_tdata_q <= {3'd0, res_len, res_addr, res_ok, res_id};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ dv/rsa_checker.sv @@
// result checker for the slot allocator: follows register writes and operation beats,
// keeps its own slot table, predicts every result beat and compares it field by field
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_checker #(
	parameter int SLOT_COUNT = rsa_pkg::DEFAULT_SLOT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// [1:0] op, [25:2] request_length, [29:26] slot_id, [31:30] zero
	input  logic [rsa_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] result_id, [4] ok, [36:5] slot_address, [60:37] slot_length, [63:61] zero
	input  logic [rsa_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            fail_count,
	output int                            pending,
	output int                            checked
);

	typedef struct packed {
		logic [rsa_pkg::LEN_W-1:0]  len;
		logic [rsa_pkg::ADDR_W-1:0] addr;
		logic                       ok;
		logic [rsa_pkg::ID_W-1:0]   id;
	} slot_result_t;

	logic [rsa_pkg::ADDR_W-1:0] pool_base_q;
	logic [rsa_pkg::LEN_W-1:0]  pool_len_q;
	logic                       in_use   [SLOT_COUNT];
	logic [rsa_pkg::ADDR_W-1:0] addr_tab [SLOT_COUNT];
	logic [rsa_pkg::LEN_W-1:0]  len_tab  [SLOT_COUNT];
	logic [rsa_pkg::CNT_W-1:0]  cnt_tab  [SLOT_COUNT];

	slot_result_t predicted_results[$];
	int n_fail;
	int n_checked;

	function automatic slot_result_t apply_slot_op(rsa_pkg::op_t op,
			logic [rsa_pkg::LEN_W-1:0] req, logic [rsa_pkg::ID_W-1:0] id);
		slot_result_t r;
		logic [rsa_pkg::LEN_W-1:0] slot_size;
		int idx;
		int i;
		r = '0;
		// id lookup: only 1..SLOT_COUNT naming an in-use slot counts
		idx = (id == 0 || int'(id) > SLOT_COUNT) ? -1 : int'(id) - 1;
		if (idx >= 0 && !in_use[idx])
			idx = -1;
		case (op)
		rsa_pkg::OP_ALLOC: begin
			slot_size = rsa_pkg::LEN_W'(pool_len_q / SLOT_COUNT);
			if (pool_base_q != 0 && req <= slot_size) begin
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (!in_use[i] && !r.ok) begin
						in_use[i]   = 1'b1;
						addr_tab[i] = pool_base_q
							+ rsa_pkg::ADDR_W'(i) * rsa_pkg::ADDR_W'(slot_size);
						len_tab[i]  = req;
						cnt_tab[i]  = rsa_pkg::CNT_W'(1);
						r.id        = rsa_pkg::ID_W'(i + 1);
						r.ok        = 1'b1;
					end
				end
			end
		end
		rsa_pkg::OP_INC: begin
			if (idx >= 0) begin
				cnt_tab[idx] = cnt_tab[idx] + 1'b1;
				r.ok = 1'b1;
			end
		end
		rsa_pkg::OP_DEC: begin
			if (idx >= 0) begin
				cnt_tab[idx] = cnt_tab[idx] - 1'b1;
				if (cnt_tab[idx] == 0)
					in_use[idx] = 1'b0;
				r.ok = 1'b1;
			end
		end
		default: begin
			if (idx >= 0) begin
				r.addr = addr_tab[idx];
				r.len  = len_tab[idx];
				r.ok   = 1'b1;
			end
		end
		endcase
		return r;
	endfunction

	function automatic int field_differs(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		int bad;
		if (!arst_n) begin
			pool_base_q = '0;
			pool_len_q  = '0;
			for (int k = 0; k < SLOT_COUNT; k++)
				in_use[k] = 1'b0;
			predicted_results.delete();
			n_fail    = 0;
			n_checked = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			// output side first: a beat leaving now belongs to an older operation
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %0h",
						$time, m_tdata);
					n_fail++;
				end else begin
					want = predicted_results.pop_front();
					bad = field_differs("result_id", 64'(want.id), 64'(m_tdata[3:0]))
						+ field_differs("ok", 64'(want.ok), 64'(m_tdata[4]))
						+ field_differs("slot_address", 64'(want.addr),
							64'(m_tdata[36:5]))
						+ field_differs("slot_length", 64'(want.len),
							64'(m_tdata[60:37]));
					if (bad != 0)
						n_fail++;
				end
				n_checked++;
			end
			if (cfg_we) begin
				if (cfg_index == rsa_pkg::REG_POOL_BASE)
					pool_base_q = cfg_wdata;
				else
					pool_len_q = cfg_wdata[rsa_pkg::LEN_W-1:0];
			end
			if (s_tvalid && s_tready)
				predicted_results.push_back(apply_slot_op(rsa_pkg::op_t'(s_tdata[1:0]),
					s_tdata[25:2], s_tdata[29:26]));
			fail_count <= n_fail;
			pending    <= predicted_results.size();
			checked    <= n_checked;
		end
	end

endmodule

@@ dv/tb_top.sv @@
// top of the slot allocator testbench: clock, reset, register writes, operation and
// result-side stimulus with random idling, watchdog and verdict
// depends on rsa_pkg, refcounted_slot_allocator_core and rsa_checker
`timescale 1ns / 1ps

module tb_top;

	localparam int NUM_SLOTS      = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES     = 9;
	localparam int PHASE_OPS      = 80;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic [rsa_pkg::S_DATA_W-1:0]  s_tdata   = '0;
	logic                          m_tready  = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic                          cfg_index = 1'b0;
	logic [rsa_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                          s_tready;
	logic                          m_tvalid;
	logic [rsa_pkg::M_DATA_W-1:0]  m_tdata;

	int fail_count;
	int pending;
	int checked;
	int ops_sent      = 0;
	int settings_used = 0;
	int idle_cycles   = 0;
	int rx_stall      = 0;
	bit tx_free_run   = 1'b0;
	bit rx_free_run   = 1'b0;
	logic [rsa_pkg::LEN_W-1:0] cur_slot_size = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	refcounted_slot_allocator_core #(.SLOT_COUNT(NUM_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	rsa_checker #(.SLOT_COUNT(NUM_SLOTS)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (!rx_free_run && $urandom_range(0, 3) == 0)
				rx_stall <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_op(input rsa_pkg::op_t op, input logic [rsa_pkg::LEN_W-1:0] len,
			input logic [rsa_pkg::ID_W-1:0] id);
		int gap;
		gap = tx_free_run ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, id, len, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ops_sent++;
	endtask

	// stop sending and wait for every outstanding result beat
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// called only with the block idle
	task automatic set_pool(input logic [rsa_pkg::ADDR_W-1:0] base,
			input logic [rsa_pkg::LEN_W-1:0] len);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= rsa_pkg::REG_POOL_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= rsa_pkg::REG_POOL_LENGTH;
		cfg_wdata <= {{(rsa_pkg::CFG_W-rsa_pkg::LEN_W){1'b0}}, len};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_slot_size = rsa_pkg::LEN_W'(len / NUM_SLOTS);
		settings_used++;
	endtask

	task automatic random_op();
		rsa_pkg::op_t op;
		logic [rsa_pkg::LEN_W-1:0] len;
		logic [rsa_pkg::ID_W-1:0] id;
		int r;
		r = $urandom_range(0, 99);
		// allocate and decrement dominate so slots fill up and get recycled
		if (r < 35)
			op = rsa_pkg::OP_ALLOC;
		else if (r < 50)
			op = rsa_pkg::OP_INC;
		else if (r < 80)
			op = rsa_pkg::OP_DEC;
		else
			op = rsa_pkg::OP_QUERY;
		r = $urandom_range(0, 99);
		if (r < 45)
			len = rsa_pkg::LEN_W'($urandom_range(0, cur_slot_size));
		else if (r < 55)
			len = cur_slot_size;
		else if (r < 65)
			len = '0;
		else if (r < 75)
			len = cur_slot_size + 1'b1;
		else
			len = rsa_pkg::LEN_W'($urandom());
		if ($urandom_range(0, 99) < 85)
			id = rsa_pkg::ID_W'($urandom_range(1, NUM_SLOTS));
		else
			id = rsa_pkg::ID_W'($urandom_range(0, 15));
		send_op(op, len, id);
	endtask

	initial begin
		logic [rsa_pkg::ADDR_W-1:0] base;
		logic [rsa_pkg::LEN_W-1:0] plen;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// no pool configured yet
		send_op(rsa_pkg::OP_ALLOC, '0, '0);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd1);
		drain();
		// top of the address space so later slot addresses wrap
		set_pool(32'hFFFF_FF00, 24'hFF_FFFF);
		send_op(rsa_pkg::OP_ALLOC, cur_slot_size, '0);
		send_op(rsa_pkg::OP_ALLOC, cur_slot_size + 1'b1, '0);
		send_op(rsa_pkg::OP_ALLOC, '0, 4'hF);
		repeat (6) send_op(rsa_pkg::OP_ALLOC,
			rsa_pkg::LEN_W'($urandom_range(0, cur_slot_size)), '0);
		send_op(rsa_pkg::OP_ALLOC, '0, '0);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd0);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd9);
		send_op(rsa_pkg::OP_QUERY, 24'hFF_FFFF, 4'd15);
		send_op(rsa_pkg::OP_INC, '0, 4'd0);
		send_op(rsa_pkg::OP_DEC, '0, 4'd9);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd8);
		send_op(rsa_pkg::OP_INC, '0, 4'd2);
		send_op(rsa_pkg::OP_DEC, '0, 4'd2);
		send_op(rsa_pkg::OP_DEC, '0, 4'd2);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd2);
		send_op(rsa_pkg::OP_INC, '0, 4'd2);
		send_op(rsa_pkg::OP_ALLOC, 24'hFF_FFFF, '0);
		send_op(rsa_pkg::OP_ALLOC, 24'd5, '0);

		// pile references on slot 1 back-to-back, then release them all
		tx_free_run = 1'b1;
		rx_free_run = 1'b1;
		repeat (12) send_op(rsa_pkg::OP_INC, '0, 4'd1);
		send_op(rsa_pkg::OP_DEC, '0, 4'd1);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd1);
		send_op(rsa_pkg::OP_INC, '0, 4'd1);
		send_op(rsa_pkg::OP_INC, '0, 4'd1);
		send_op(rsa_pkg::OP_DEC, '0, 4'd1);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd1);
		repeat (14) send_op(rsa_pkg::OP_DEC, '0, 4'd1);
		send_op(rsa_pkg::OP_QUERY, '0, 4'd1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			base = $urandom();
			plen = rsa_pkg::LEN_W'($urandom());
			case (ph)
			0: base = '0;
			1: begin
				base = 32'hFFFF_FFFF;
				plen = 24'hFF_FFFF;
			end
			2: plen = '0;
			3: plen = 24'd7;
			4: plen = 24'd8;
			5: begin
				base = 32'd1;
				plen = 24'h00_0400;
			end
			default: ;
			endcase
			drain();
			set_pool(base, plen);
			tx_free_run = ($urandom_range(0, 3) == 0);
			rx_free_run = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_OPS; n++) begin
				// one mid-phase hold-off until the result side is empty
				if (ph == 6 && n == PHASE_OPS / 2)
					drain();
				random_op();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d operations over %0d pool settings, slot release at zero included",
			ops_sent, settings_used);
		$display("%0d result beats compared against the predicted slot table", checked);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
design/rsa_pkg.sv
design/refcounted_slot_allocator_core.sv
dv/rsa_checker.sv
dv/tb_top.sv
